// ----- hw/rtl/lis_pkg.sv -----
// ----------------------------------------------------------------------------
// lis_pkg
// Shared widths and types for the longest increasing subsequence unit.
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int VALUE_W  = 32;  // sequence value, signed
  localparam int INDEX_W  = 10;  // item_index, position, best_end
  localparam int LENGTH_W = 11;  // predecessor, best_length

  typedef logic signed [VALUE_W-1:0]  value_t;
  typedef logic        [INDEX_W-1:0]  index_t;
  typedef logic        [LENGTH_W-1:0] length_t;
  typedef logic signed [LENGTH_W-1:0] pred_t;

  localparam pred_t PRED_NONE = '1;  // -1: run starts at this item

endpackage

// ----- hw/rtl/lis_ram.sv -----
// ----------------------------------------------------------------------------
// lis_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lis_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/longest_increasing_subsequence_unit.sv -----
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_unit
// Streaming longest strictly increasing subsequence (patience method).
// ----------------------------------------------------------------------------
// Takes one signed 32-bit value per input transaction and returns one result
// transaction for it: the length slot the item lands in, the index of its
// predecessor in that run (-1 if none), and the longest length so far with the
// index of the item ending it. in_start_req begins a new sequence. Once
// MAX_ITEMS items of a sequence have been taken, further items are ignored and
// reported with out_overflow set. The tail table (value and item index per run
// length) lives in one RAM of MAX_ITEMS words; no clearing pass is needed
// since only slots below the current length are ever read. A searched item
// makes at most ceil(log2(MAX_ITEMS)) binary-search probes, 10 for 1024
// entries, since it sees at most MAX_ITEMS - 1 valid tails; an ignored item
// skips the search. The probes go through the RAM's single read port, one
// probe per cycle.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted and searched.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_unit #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  lis_pkg::value_t         in_value,
  input  logic                    in_start_req,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output lis_pkg::index_t         out_item_index,
  output lis_pkg::index_t         out_position,
  output lis_pkg::pred_t          out_predecessor,
  output lis_pkg::length_t        out_best_length,
  output lis_pkg::index_t         out_best_end,
  output logic                    out_overflow
);

  import lis_pkg::*;

  // Widths that follow from the table size.
  localparam int IDX_W  = $clog2(MAX_ITEMS);      // RAM address / stored index
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);  // counts up to MAX_ITEMS
  localparam int WORD_W = VALUE_W + IDX_W;        // {tail value, tail item}

  localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_ITEMS);

  // Controller states.
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for an input transaction
  localparam logic [1:0] ST_SRCH = 2'd1;  // binary search, one probe per cycle
  localparam logic [1:0] ST_FIN  = 2'd2;  // table update and result load

  // Control state.
  logic [1:0]       state_r, state_nxt;
  logic             pend_r, pend_nxt;        // a probe read is in flight
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] run_count_r, run_count_nxt;
  logic [CNT_W-1:0] item_count_r, item_count_nxt;

  // Per-item working registers.
  value_t           value_r, value_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt;
  logic             has_pred_r, has_pred_nxt;
  logic [IDX_W-1:0] pred_item_r, pred_item_nxt;
  logic [IDX_W-1:0] best_end_r, best_end_nxt;

  // Output register.
  index_t           o_item_r, o_item_nxt;
  index_t           o_pos_r, o_pos_nxt;
  pred_t            o_pred_r, o_pred_nxt;
  length_t          o_len_r, o_len_nxt;
  index_t           o_end_r, o_end_nxt;
  logic             o_ovf_r, o_ovf_nxt;

  // RAM interface.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  value_t            rd_value;
  logic [IDX_W-1:0]  rd_item;

  // Search datapath.
  logic [CNT_W-1:0] lo_c, hi_c, mid_c;
  logic [CNT_W:0]   mid_sum;
  logic             has_pred_c;
  logic [IDX_W-1:0] pred_item_c;

  logic             in_take;
  logic             out_free;
  logic [CNT_W-1:0] item_eff, run_eff;

  lis_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ITEMS)
  ) u_tail_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_value = ram_rdata[WORD_W-1 -: VALUE_W];
  assign rd_item  = ram_rdata[IDX_W-1:0];

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // A start flag clears both counts before the item is looked at.
  assign item_eff = in_start_req ? '0 : item_count_r;
  assign run_eff  = in_start_req ? '0 : run_count_r;

  // Fold in the probe that returned this cycle, then pick the next probe.
  // The probe address goes straight to the RAM, so each cycle retires one
  // probe and launches the next.
  always_comb begin
    lo_c        = lo_r;
    hi_c        = hi_r;
    has_pred_c  = has_pred_r;
    pred_item_c = pred_item_r;
    if (pend_r) begin
      if (rd_value < value_r) begin
        lo_c        = mid_r;
        has_pred_c  = 1'b1;
        pred_item_c = rd_item;
      end else begin
        hi_c = mid_r - CNT_W'(1);
      end
    end
    mid_sum = {1'b0, lo_c} + {1'b0, hi_c} + (CNT_W+1)'(1);
    mid_c   = mid_sum[CNT_W:1];
  end

  assign ram_raddr = IDX_W'(mid_c - CNT_W'(1));

  // Table write: slot lo gets this item as its new tail.
  assign ram_we    = (state_r == ST_FIN) && !ovf_r && out_free;
  assign ram_waddr = IDX_W'(lo_r);
  assign ram_wdata = {value_r, IDX_W'(item_count_r)};

  always_comb begin
    state_nxt      = state_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && out_stall;
    run_count_nxt  = run_count_r;
    item_count_nxt = item_count_r;
    value_nxt      = value_r;
    ovf_nxt        = ovf_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    has_pred_nxt   = has_pred_r;
    pred_item_nxt  = pred_item_r;
    best_end_nxt   = best_end_r;
    o_item_nxt     = o_item_r;
    o_pos_nxt      = o_pos_r;
    o_pred_nxt     = o_pred_r;
    o_len_nxt      = o_len_r;
    o_end_nxt      = o_end_r;
    o_ovf_nxt      = o_ovf_r;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          value_nxt      = in_value;
          run_count_nxt  = run_eff;
          item_count_nxt = item_eff;
          ovf_nxt        = (item_eff == CAPACITY);
          lo_nxt         = '0;
          hi_nxt         = run_eff;
          has_pred_nxt   = 1'b0;
          pend_nxt       = 1'b0;
          // Ignored items skip the search entirely.
          state_nxt      = (item_eff == CAPACITY) ? ST_FIN : ST_SRCH;
        end
      end

      ST_SRCH: begin
        lo_nxt        = lo_c;
        hi_nxt        = hi_c;
        has_pred_nxt  = has_pred_c;
        pred_item_nxt = pred_item_c;
        mid_nxt       = mid_c;
        if (lo_c < hi_c) begin
          pend_nxt = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (ovf_r) begin
            o_item_nxt = '0;
            o_pos_nxt  = '0;
            o_pred_nxt = PRED_NONE;
            o_len_nxt  = LENGTH_W'(run_count_r);
            o_end_nxt  = (run_count_r != '0) ? INDEX_W'(best_end_r) : '0;
            o_ovf_nxt  = 1'b1;
          end else begin
            // Appending grows the longest run; touching its last slot
            // (append or replace) moves its end to this item.
            if (lo_r == run_count_r) begin
              run_count_nxt = run_count_r + CNT_W'(1);
            end
            if ((lo_r + CNT_W'(1)) >= run_count_r) begin
              best_end_nxt = IDX_W'(item_count_r);
            end
            item_count_nxt = item_count_r + CNT_W'(1);
            o_item_nxt     = INDEX_W'(item_count_r);
            o_pos_nxt      = INDEX_W'(lo_r);
            o_pred_nxt     = has_pred_r ? pred_t'(LENGTH_W'(pred_item_r)) : PRED_NONE;
            o_len_nxt      = LENGTH_W'(run_count_nxt);
            o_end_nxt      = INDEX_W'(best_end_nxt);
            o_ovf_nxt      = 1'b0;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      run_count_r  <= '0;
      item_count_r <= '0;
    end else begin
      state_r      <= state_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
      run_count_r  <= run_count_nxt;
      item_count_r <= item_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r     <= value_nxt;
    ovf_r       <= ovf_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    has_pred_r  <= has_pred_nxt;
    pred_item_r <= pred_item_nxt;
    best_end_r  <= best_end_nxt;
    o_item_r    <= o_item_nxt;
    o_pos_r     <= o_pos_nxt;
    o_pred_r    <= o_pred_nxt;
    o_len_r     <= o_len_nxt;
    o_end_r     <= o_end_nxt;
    o_ovf_r     <= o_ovf_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_item_index  = o_item_r;
  assign out_position    = o_pos_r;
  assign out_predecessor = o_pred_r;
  assign out_best_length = o_len_r;
  assign out_best_end    = o_end_r;
  assign out_overflow    = o_ovf_r;

  // The longest run can never exceed the items seen, nor the table size.
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (run_count_r <= item_count_r) && (item_count_r <= CAPACITY))
    else $error("run or item count out of range");

  // Search window stays ordered and inside the valid part of the table.
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> ((lo_r <= hi_r) && (hi_r <= run_count_r)))
    else $error("search window out of order");

  // A slot to be written lies at most one past the longest run.
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !ovf_r) |-> (lo_r <= run_count_r && item_count_r < CAPACITY))
    else $error("write slot beyond table");

  // The table is written only on the cycle a result is loaded.
  a_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (out_valid_r && !o_ovf_r && state_r == ST_IDLE))
    else $error("table write without result");

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for longest_increasing_subsequence_unit.
// ----------------------------------------------------------------------------
// A directed table walks the value extremes, equal values, back-to-back
// sequence restarts and the first item after reset. Random sequences follow:
// wide, narrow (many equal values), mostly rising and falling runs, some
// without a start flag so that they run on into the previous sequence. One
// strictly rising sequence fills the whole tail table and is then fed past
// capacity. Results are checked against the table where it gives them, else
// a patience-sort model. Traffic runs in three idle profiles: receiver mostly
// stalled, sender mostly idle, then full rate with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lis_pkg::*;

  localparam int          MAX_ITEMS    = 1024;
  localparam int          RAND_ITEMS   = 1800;
  localparam int          HOLD_CYCLES  = 400;      // long receiver hold-off
  localparam int          DRAIN_CYCLES = 40;       // quiet after the last result
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          MAX_REPORTS  = 40;

  localparam value_t V_MIN = 32'sh8000_0000;
  localparam value_t V_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    index_t  item_index;
    index_t  position;
    pred_t   predecessor;
    length_t best_length;
    index_t  best_end;
    logic    overflow;
  } lis_result_t;

  // one row of the directed table; res is only used when known is set
  typedef struct packed {
    value_t      value;
    logic        start;
    logic        known;
    lis_result_t res;
  } stim_row_t;

  typedef enum int {SEQ_WIDE, SEQ_NARROW, SEQ_RISING, SEQ_FALLING} seq_kind_e;
  typedef enum int {PH_RX_SLOW, PH_TX_SLOW, PH_NO_IDLE} phase_e;

  localparam int DIR_N = 24;
  localparam stim_row_t DIR_ROWS [DIR_N] = '{
    // first item after reset, no start flag
    '{32'sd5,   1'b0, 1'b1, '{10'd0, 10'd0, PRED_NONE, 11'd1, 10'd0, 1'b0}},
    // smaller value replaces slot 0
    '{32'sd3,   1'b0, 1'b1, '{10'd1, 10'd0, PRED_NONE, 11'd1, 10'd1, 1'b0}},
    // equal value: strict compare, same slot
    '{32'sd3,   1'b0, 1'b1, '{10'd2, 10'd0, PRED_NONE, 11'd1, 10'd2, 1'b0}},
    '{32'sd7,   1'b0, 1'b1, '{10'd3, 10'd1, 11'sd2,    11'd2, 10'd3, 1'b0}},
    // restart on the most negative value
    '{V_MIN,    1'b1, 1'b1, '{10'd0, 10'd0, PRED_NONE, 11'd1, 10'd0, 1'b0}},
    '{V_MAX,    1'b0, 1'b1, '{10'd1, 10'd1, 11'sd0,    11'd2, 10'd1, 1'b0}},
    '{V_MAX,    1'b0, 1'b1, '{10'd2, 10'd1, 11'sd0,    11'd2, 10'd2, 1'b0}},
    '{V_MIN,    1'b0, 1'b1, '{10'd3, 10'd0, PRED_NONE, 11'd2, 10'd2, 1'b0}},
    '{-32'sd1,  1'b0, 1'b1, '{10'd4, 10'd1, 11'sd3,    11'd2, 10'd4, 1'b0}},
    '{32'sd0,   1'b0, 1'b1, '{10'd5, 10'd2, 11'sd4,    11'd3, 10'd5, 1'b0}},
    '{32'sh8000_0001, 1'b0, 1'b0, '0},
    // single-item sequences back to back
    '{32'sd42,  1'b1, 1'b1, '{10'd0, 10'd0, PRED_NONE, 11'd1, 10'd0, 1'b0}},
    '{32'sd42,  1'b1, 1'b1, '{10'd0, 10'd0, PRED_NONE, 11'd1, 10'd0, 1'b0}},
    '{32'sd100, 1'b1, 1'b0, '0},
    '{32'sd90,  1'b0, 1'b0, '0},
    '{32'sd80,  1'b0, 1'b0, '0},
    '{32'sd85,  1'b0, 1'b0, '0},
    '{32'sd95,  1'b0, 1'b0, '0},
    '{32'sd200, 1'b0, 1'b0, '0},
    '{32'sd150, 1'b0, 1'b0, '0},
    '{-32'sd100, 1'b0, 1'b0, '0},
    '{32'sh5555_5555, 1'b1, 1'b0, '0},
    '{32'shAAAA_AAAA, 1'b0, 1'b0, '0},
    '{32'sh7FFF_FFFE, 1'b0, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  logic    in_valid;
  logic    in_stall;
  value_t  in_value;
  logic    in_start_req;

  logic    out_valid;
  logic    out_stall;
  index_t  out_item_index;
  index_t  out_position;
  pred_t   out_predecessor;
  length_t out_best_length;
  index_t  out_best_end;
  logic    out_overflow;

  longest_increasing_subsequence_unit #(.MAX_ITEMS(MAX_ITEMS)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .in_start_req    (in_start_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item_index  (out_item_index),
    .out_position    (out_position),
    .out_predecessor (out_predecessor),
    .out_best_length (out_best_length),
    .out_best_end    (out_best_end),
    .out_overflow    (out_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // --------------------------------------------------------------------------
  // Patience-sort model: smallest tail value and its item index per run length
  // --------------------------------------------------------------------------
  value_t      tail_value [MAX_ITEMS];
  index_t      tail_item  [MAX_ITEMS];
  int unsigned run_len  = 0;
  int unsigned item_cnt = 0;

  lis_result_t due_results[$];   // results owed by the unit, oldest first
  int          fail_count = 0;
  int          send_pct   = 15;  // sender idle chance per cycle, percent
  int          recv_pct   = 85;  // receiver stall chance per cycle, percent
  bit          hold_req   = 1'b0;
  int unsigned cycle_cnt  = 0;

  function automatic lis_result_t lis_extend(value_t v, logic s);
    lis_result_t r;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned slot;
    if (s) begin
      run_len  = 0;
      item_cnt = 0;
    end
    r = '0;
    // past capacity: nothing changes, report the current best run
    if (item_cnt >= MAX_ITEMS) begin
      r.predecessor = PRED_NONE;
      r.best_length = length_t'(run_len);
      r.best_end    = (run_len > 0) ? tail_item[run_len-1] : '0;
      r.overflow    = 1'b1;
      return r;
    end
    // slot = number of tails strictly below v
    lo = 0;
    hi = run_len;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (tail_value[mid-1] < v) lo = mid;
      else hi = mid - 1;
    end
    slot = (lo >= MAX_ITEMS) ? MAX_ITEMS - 1 : lo;
    r.predecessor = (slot == 0) ? PRED_NONE : pred_t'({1'b0, tail_item[slot-1]});
    tail_value[slot] = v;
    tail_item[slot]  = index_t'(item_cnt);
    if (slot + 1 > run_len) run_len = slot + 1;
    r.item_index  = index_t'(item_cnt);
    r.position    = index_t'(slot);
    r.best_length = length_t'(run_len);
    r.best_end    = tail_item[run_len-1];
    item_cnt++;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one transaction, hold it until taken, log what the unit owes for it,
  // then maybe idle. in_valid stays high into the next call when no idle
  // cycle is drawn, so it never gets two updates in one step.
  task automatic send_txn(value_t v, logic s, logic known, lis_result_t typed);
    lis_result_t r;
    in_valid     <= 1'b1;
    in_value     <= v;
    in_start_req <= s;
    do @(posedge clk); while (in_stall);
    r = lis_extend(v, s);
    due_results.insert(due_results.size(), known ? typed : r);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Sender pause: stop offering until every owed result is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  initial begin
    phase_e    cur_phase;
    seq_kind_e kind;
    int        rand_sent;
    int        seq_len;
    int        acc;
    longint    rise;
    bit        long_done;
    bit        force_start;
    bit        first_start;
    value_t    v;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_value     <= '0;
    in_start_req <= 1'b0;
    cur_phase    = PH_RX_SLOW;
    rand_sent    = 0;
    long_done    = 1'b0;
    force_start  = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i])
      send_txn(DIR_ROWS[i].value, DIR_ROWS[i].start, DIR_ROWS[i].known, DIR_ROWS[i].res);
    wait_drained();

    while (rand_sent < RAND_ITEMS) begin
      // idle profile switches, each behind a full drain
      if (cur_phase == PH_RX_SLOW && rand_sent >= 350) begin
        wait_drained();
        cur_phase = PH_TX_SLOW;
        send_pct  = 85;
        recv_pct  = 15;
      end else if (cur_phase == PH_TX_SLOW && rand_sent >= 700) begin
        wait_drained();
        cur_phase = PH_NO_IDLE;
        send_pct  = 0;
        recv_pct  = 0;
        hold_req  = 1'b1;   // receiver blocks while items keep coming
      end

      if (cur_phase == PH_NO_IDLE && !long_done) begin
        // strictly rising run that fills every slot, reaching full length
        rise = -64'sd2147483648 + longint'($urandom_range(0, 1000));
        for (int k = 0; k < MAX_ITEMS; k++) begin
          send_txn(value_t'(rise), k == 0, 1'b0, '0);
          rise += longint'($urandom_range(1, 4000000));
        end
        // past capacity: ignored and flagged
        repeat (8) send_txn(value_t'($urandom), 1'b0, 1'b0, '0);
        rand_sent   += MAX_ITEMS + 8;
        long_done   = 1'b1;
        force_start = 1'b1;
      end else begin
        seq_len     = $urandom_range(1, 40);
        kind        = seq_kind_e'($urandom_range(0, 3));
        // now and then no start flag: the run continues the last sequence
        first_start = force_start || ($urandom_range(9) != 0);
        force_start = 1'b0;
        acc         = int'($urandom_range(0, 2000)) - 1000;
        for (int k = 0; k < seq_len; k++) begin
          case (kind)
            SEQ_WIDE:    v = value_t'($urandom);
            SEQ_NARROW:  v = value_t'(int'($urandom_range(0, 8)) - 4);
            SEQ_RISING: begin
              acc += int'($urandom_range(0, 50)) - 10;
              v = value_t'(acc);
            end
            default: begin
              acc -= int'($urandom_range(0, 20));
              v = value_t'(acc);
            end
          endcase
          send_txn(v, first_start && k == 0, 1'b0, '0);
        end
        rand_sent += seq_len;
      end
    end

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stall, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  // Every accepted result transaction is matched against the oldest owed one.
  always @(posedge clk) begin
    lis_result_t got;
    lis_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_item_index, out_position, out_predecessor, out_best_length,
              out_best_end, out_overflow};
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result transaction idx=%0d pos=%0d", $realtime,
                   got.item_index, got.position);
      end else begin
        want = due_results.pop_front();
        if (got.item_index !== want.item_index || got.position !== want.position ||
            got.predecessor !== want.predecessor ||
            got.best_length !== want.best_length ||
            got.best_end !== want.best_end || got.overflow !== want.overflow) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: mismatch expected idx=%0d pos=%0d pred=%0d len=%0d end=%0d ovf=%0b",
                     $realtime, want.item_index, want.position, want.predecessor,
                     want.best_length, want.best_end, want.overflow);
            $display("%0t:          actual   idx=%0d pos=%0d pred=%0d len=%0d end=%0d ovf=%0b",
                     $realtime, got.item_index, got.position, got.predecessor,
                     got.best_length, got.best_end, got.overflow);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

endmodule

// ----- files.f -----
hw/rtl/lis_pkg.sv
hw/rtl/lis_ram.sv
hw/rtl/longest_increasing_subsequence_unit.sv
sim/tb_top.sv
